### rtl/svf_pkg.sv
`timescale 1ns / 1ps

package svf_pkg;

   // Field and state widths
   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 18;
   localparam int DAMP_W   = 24;
   localparam int LIMIT_W  = 16;
   localparam int PASS_W   = 4;
   localparam int STATE_W  = 40;
   localparam int WIDE_W   = 51;
   localparam int HALF_W   = 12;
   localparam int PP_W     = STATE_W + HALF_W + 1;
   localparam int ACC_W    = 65;
   localparam int PROD_W   = ACC_W - 16;

   // Pass count limits
   localparam logic [PASS_W-1:0] MAX_OVERSAMPLE = 4'd8;
   localparam logic [PASS_W-1:0] DEFAULT_PASSES = 4'd3;

   // Configuration register indexes and reset values
   localparam logic CSR_OVERSAMPLE = 1'b0;
   localparam logic CSR_LIMIT      = 1'b1;
   localparam logic [PASS_W-1:0]  OVERSAMPLE_RESET = 4'd3;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 16'd1092;

   // Q.16 constants
   localparam logic [COEF_W-1:0] TWO_Q16  = 18'd131072;
   localparam logic [ACC_W-1:0]  HALF_Q16 = 65'd32768;

   // Datapath operations
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_LOAD   = 3'd1;
   localparam logic [2:0] OP_MUL_LO = 3'd2;
   localparam logic [2:0] OP_MUL_HI = 3'd3;
   localparam logic [2:0] OP_FLOOR  = 3'd4;
   localparam logic [2:0] OP_HP     = 3'd5;
   localparam logic [2:0] OP_BP     = 3'd6;
   localparam logic [2:0] OP_LP     = 3'd7;

   // Multiplier operand pairs
   localparam logic [1:0] SEL_LIM = 2'd0;
   localparam logic [1:0] SEL_BQ  = 2'd1;
   localparam logic [1:0] SEL_HF  = 2'd2;
   localparam logic [1:0] SEL_BF  = 2'd3;

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] sel;
      logic       load_out;
   } svf_cmd_type;

   // Saturate a wide signed value to the 40-bit state range.
   function automatic logic signed [STATE_W-1:0] sat40(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-STATE_W:0] top;
      top = v[WIDE_W-1:STATE_W-1];
      if (&top || ~|top) begin
         return v[STATE_W-1:0];
      end else if (v[WIDE_W-1]) begin
         return {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(STATE_W-1){1'b1}}};
      end
   endfunction

   // Round a Q.16 state value half up to whole units and saturate to 24 bits.
   function automatic logic signed [SAMPLE_W-1:0] to_out(input logic signed [STATE_W-1:0] v);
      logic signed [STATE_W:0] r;
      logic signed [STATE_W-16:0] t;
      r = {v[STATE_W-1], v} + 41'sd32768;
      t = r[STATE_W:16];
      if (t[STATE_W-16] == t[STATE_W-17]) begin
         return t[SAMPLE_W-1:0];
      end else if (t[STATE_W-16]) begin
         return {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   endfunction

endpackage

### rtl/state_variable_filter_oversampled.sv
`timescale 1ns / 1ps
// Channel   Handshake                Word
// req       req_valid / req_ready    req_sample, req_tune_coef, req_damping
// rsp       rsp_valid / rsp_ready    rsp_highpass_out, rsp_lowpass_out,
//                                    rsp_bandpass_out, rsp_bandreject_out
// csr       csr_write_en             csr_index, csr_wdata
//
// Each word is worked in P passes, P being the pass count (1 to 8): each pass makes three
// 40 x 24 products on one shared multiplier, each as a low and a high half product, and
// each product is followed by one of the three adds.
// Reset clears the filter state and loads the register reset values.
// A finished word waits in the output register; the next word is taken while it waits,
// and only a second finished word stalls until the first has been taken.

module state_variable_filter_oversampled import svf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [COEF_W-1:0]          req_tune_coef,
   input  logic [DAMP_W-1:0]          req_damping,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_highpass_out,
   output logic signed [SAMPLE_W-1:0] rsp_lowpass_out,
   output logic signed [SAMPLE_W-1:0] rsp_bandpass_out,
   output logic signed [SAMPLE_W-1:0] rsp_bandreject_out,
   input  logic                       csr_write_en,
   input  logic                       csr_index,
   input  logic [LIMIT_W-1:0]         csr_wdata
);

   logic [PASS_W-1:0]  oversample_ff;
   logic [LIMIT_W-1:0] limit_ff;
   svf_cmd_type        cmd;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         oversample_ff <= OVERSAMPLE_RESET;
         limit_ff      <= LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_OVERSAMPLE: oversample_ff <= csr_wdata[PASS_W-1:0];
            default:        limit_ff      <= csr_wdata;
         endcase
      end
   end

   svf_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .oversample_count (oversample_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .cmd              (cmd)
   );

   svf_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .limit_scale        (limit_ff),
      .req_sample         (req_sample),
      .req_tune_coef      (req_tune_coef),
      .req_damping        (req_damping),
      .rsp_highpass_out   (rsp_highpass_out),
      .rsp_lowpass_out    (rsp_lowpass_out),
      .rsp_bandpass_out   (rsp_bandpass_out),
      .rsp_bandreject_out (rsp_bandreject_out)
   );

   // A word is captured only on an accepting edge.
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOAD) |-> (req_valid && req_ready))
      else $error("word captured without an input handshake");

   // After acceptance the block is not ready in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted twice in a row");

   // Loading the output register raises the result valid.
   a_valid_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("result loaded but not presented");

   // The output register is never overwritten while a result waits.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && rsp_valid) |-> rsp_ready)
      else $error("pending result overwritten");

endmodule

### rtl/svf_dp.sv
`timescale 1ns / 1ps

module svf_dp import svf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  svf_cmd_type                cmd,
   input  logic [LIMIT_W-1:0]         limit_scale,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [COEF_W-1:0]          req_tune_coef,
   input  logic [DAMP_W-1:0]          req_damping,
   output logic signed [SAMPLE_W-1:0] rsp_highpass_out,
   output logic signed [SAMPLE_W-1:0] rsp_lowpass_out,
   output logic signed [SAMPLE_W-1:0] rsp_bandpass_out,
   output logic signed [SAMPLE_W-1:0] rsp_bandreject_out
);

   logic signed [SAMPLE_W-1:0] x_ff;
   logic [COEF_W-1:0]          f_ff;
   logic [DAMP_W-1:0]          q_ff;
   logic signed [STATE_W-1:0]  bd_ff, bd_in;
   logic signed [STATE_W-1:0]  ld_ff, ld_in;
   logic signed [STATE_W-1:0]  hp_ff, bp_ff, br_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [SAMPLE_W-1:0] hp_out_ff, lp_out_ff, bp_out_ff, br_out_ff;

   logic [COEF_W-1:0]          lim_base;
   logic signed [STATE_W-1:0]  mul_a;
   logic [DAMP_W-1:0]          mul_c;
   logic [HALF_W-1:0]          c_half;
   logic signed [PP_W-1:0]     pp;
   logic signed [ACC_W-1:0]    pp_ext;
   logic signed [ACC_W-1:0]    acc_in;
   logic signed [PROD_W-1:0]   prod;
   logic signed [WIDE_W-1:0]   prod_w, x_w, bd_w, ld_w, hp_w;
   logic signed [STATE_W-1:0]  hp_sat, bp_sat, lp_sat, br_sat;

   // Operand selection for the shared multiplier.
   always_comb begin
      lim_base = (f_ff < TWO_Q16) ? COEF_W'(TWO_Q16 - f_ff) : '0;
      unique case (cmd.sel)
         SEL_LIM: begin
            mul_a = {{(STATE_W-COEF_W){1'b0}}, lim_base};
            mul_c = {{(DAMP_W-LIMIT_W){1'b0}}, limit_scale};
         end
         SEL_BQ: begin
            mul_a = bd_ff;
            mul_c = q_ff;
         end
         SEL_HF: begin
            mul_a = hp_ff;
            mul_c = {{(DAMP_W-COEF_W){1'b0}}, f_ff};
         end
         default: begin
            mul_a = bd_ff;
            mul_c = {{(DAMP_W-COEF_W){1'b0}}, f_ff};
         end
      endcase
   end

   // One 40 x 13 partial product per cycle; the low half starts the sum with the rounding bias.
   assign c_half = (cmd.op == OP_MUL_HI) ? mul_c[DAMP_W-1:HALF_W] : mul_c[HALF_W-1:0];
   assign pp     = PP_W'(mul_a) * PP_W'($signed({1'b0, c_half}));
   assign pp_ext = {{(ACC_W-PP_W){pp[PP_W-1]}}, pp};
   assign acc_in = (cmd.op == OP_MUL_HI) ? acc_ff + (pp_ext <<< HALF_W)
                                         : pp_ext + $signed(HALF_Q16);

   // Rounded product and the recursion adds; the adds are saturated to the state range.
   assign prod   = acc_ff[ACC_W-1:16];
   assign prod_w = {{(WIDE_W-PROD_W){prod[PROD_W-1]}}, prod};
   assign x_w    = {{(WIDE_W-SAMPLE_W-16){x_ff[SAMPLE_W-1]}}, x_ff, 16'd0};
   assign bd_w   = {{(WIDE_W-STATE_W){bd_ff[STATE_W-1]}}, bd_ff};
   assign ld_w   = {{(WIDE_W-STATE_W){ld_ff[STATE_W-1]}}, ld_ff};
   assign hp_w   = {{(WIDE_W-STATE_W){hp_ff[STATE_W-1]}}, hp_ff};
   assign hp_sat = sat40(x_w - prod_w - ld_w);
   assign bp_sat = sat40(prod_w + bd_w);
   assign lp_sat = sat40(prod_w + ld_w);
   assign br_sat = sat40({{(WIDE_W-STATE_W){lp_sat[STATE_W-1]}}, lp_sat} + hp_w);

   // Filter state: band and low delays move together at the end of each pass.
   always_comb begin
      bd_in = bd_ff;
      ld_in = ld_ff;
      if (cmd.op == OP_LP) begin
         bd_in = bp_ff;
         ld_in = lp_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bd_ff <= '0;
         ld_ff <= '0;
      end else begin
         bd_ff <= bd_in;
         ld_ff <= ld_in;
      end
   end

   // Working registers of the current word.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            x_ff <= req_sample;
            f_ff <= req_tune_coef;
            q_ff <= req_damping;
         end
         OP_MUL_LO, OP_MUL_HI: begin
            acc_ff <= acc_in;
         end
         OP_FLOOR: begin
            if (q_ff < prod[DAMP_W-1:0]) begin
               q_ff <= prod[DAMP_W-1:0];
            end
         end
         OP_HP: begin
            hp_ff <= hp_sat;
         end
         OP_BP: begin
            bp_ff <= bp_sat;
         end
         OP_LP: begin
            br_ff <= br_sat;
         end
         default: begin
         end
      endcase
   end

   // Output register, loaded once the last pass has finished.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         hp_out_ff <= to_out(hp_ff);
         lp_out_ff <= to_out(ld_ff);
         bp_out_ff <= to_out(bd_ff);
         br_out_ff <= to_out(br_ff);
      end
   end

   assign rsp_highpass_out   = hp_out_ff;
   assign rsp_lowpass_out    = lp_out_ff;
   assign rsp_bandpass_out   = bp_out_ff;
   assign rsp_bandreject_out = br_out_ff;

endmodule

### rtl/svf_ctrl.sv
`timescale 1ns / 1ps

module svf_ctrl import svf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [PASS_W-1:0] oversample_count,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output svf_cmd_type       cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_LIM_LO = 4'd1;
   localparam logic [3:0] ST_LIM_HI = 4'd2;
   localparam logic [3:0] ST_FLOOR  = 4'd3;
   localparam logic [3:0] ST_BQ_LO  = 4'd4;
   localparam logic [3:0] ST_BQ_HI  = 4'd5;
   localparam logic [3:0] ST_HP     = 4'd6;
   localparam logic [3:0] ST_HF_LO  = 4'd7;
   localparam logic [3:0] ST_HF_HI  = 4'd8;
   localparam logic [3:0] ST_BP     = 4'd9;
   localparam logic [3:0] ST_BF_LO  = 4'd10;
   localparam logic [3:0] ST_BF_HI  = 4'd11;
   localparam logic [3:0] ST_LP     = 4'd12;
   localparam logic [3:0] ST_DONE   = 4'd13;

   logic [3:0]        state_ff, state_in;
   logic [PASS_W-1:0] passes_ff, passes_in;
   logic [PASS_W-1:0] count_ff, count_in;
   logic              valid_ff, valid_in;
   logic [PASS_W-1:0] passes_req;

   // Pass count of a new word: zero means the default, and it is capped at the maximum.
   always_comb begin
      passes_req = (oversample_count == '0) ? DEFAULT_PASSES : oversample_count;
      if (passes_req > MAX_OVERSAMPLE) begin
         passes_req = MAX_OVERSAMPLE;
      end
   end

   // Sequencer: limit product and damping floor, then three products per pass on the shared multiplier.
   always_comb begin
      state_in  = state_ff;
      passes_in = passes_ff;
      count_in  = count_ff;
      valid_in  = valid_ff && !rsp_ready;
      cmd       = '{op: OP_NONE, sel: SEL_LIM, load_out: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op    = OP_LOAD;
               passes_in = passes_req;
               count_in  = '0;
               state_in  = ST_LIM_LO;
            end
         end
         ST_LIM_LO: begin
            cmd      = '{op: OP_MUL_LO, sel: SEL_LIM, load_out: 1'b0};
            state_in = ST_LIM_HI;
         end
         ST_LIM_HI: begin
            cmd      = '{op: OP_MUL_HI, sel: SEL_LIM, load_out: 1'b0};
            state_in = ST_FLOOR;
         end
         ST_FLOOR: begin
            cmd.op   = OP_FLOOR;
            state_in = ST_BQ_LO;
         end
         ST_BQ_LO: begin
            cmd      = '{op: OP_MUL_LO, sel: SEL_BQ, load_out: 1'b0};
            state_in = ST_BQ_HI;
         end
         ST_BQ_HI: begin
            cmd      = '{op: OP_MUL_HI, sel: SEL_BQ, load_out: 1'b0};
            state_in = ST_HP;
         end
         ST_HP: begin
            cmd.op   = OP_HP;
            state_in = ST_HF_LO;
         end
         ST_HF_LO: begin
            cmd      = '{op: OP_MUL_LO, sel: SEL_HF, load_out: 1'b0};
            state_in = ST_HF_HI;
         end
         ST_HF_HI: begin
            cmd      = '{op: OP_MUL_HI, sel: SEL_HF, load_out: 1'b0};
            state_in = ST_BP;
         end
         ST_BP: begin
            cmd.op   = OP_BP;
            state_in = ST_BF_LO;
         end
         ST_BF_LO: begin
            cmd      = '{op: OP_MUL_LO, sel: SEL_BF, load_out: 1'b0};
            state_in = ST_BF_HI;
         end
         ST_BF_HI: begin
            cmd      = '{op: OP_MUL_HI, sel: SEL_BF, load_out: 1'b0};
            state_in = ST_LP;
         end
         ST_LP: begin
            cmd.op   = OP_LP;
            count_in = count_ff + 1'b1;
            state_in = (count_ff + 1'b1 == passes_ff) ? ST_DONE : ST_BQ_LO;
         end
         ST_DONE: begin
            // Wait here only while the previous result is still held.
            if (!valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         passes_ff <= DEFAULT_PASSES;
         count_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         passes_ff <= passes_in;
         count_ff  <= count_in;
         valid_ff  <= valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule
